@@ hw/rtl/lsc_pkg.sv @@
// ----------------------------------------------------------------------------
// lsc_pkg
// Types and fixed constants shared by the lidar scan cluster segmenter.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int RANGE_W    = 16;
    localparam int GAP_W      = 12;
    localparam int MINPTS_W   = 13;
    localparam int STEP_W     = 23;
    localparam int ANGLE_W    = 24;
    localparam int WIDTH_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_JUMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_POINTS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANG  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP = 3'd6;

    localparam logic [RANGE_W-1:0]        RST_MIN_RANGE  = 16'd150;
    localparam logic [RANGE_W-1:0]        RST_MAX_RANGE  = 16'd3000;
    localparam logic [RANGE_W-1:0]        RST_RANGE_JUMP = 16'd150;
    localparam logic [GAP_W-1:0]          RST_GAP_LIMIT  = 12'd2;
    localparam logic [MINPTS_W-1:0]       RST_MIN_POINTS = 13'd2;
    localparam logic signed [STEP_W-1:0]  RST_START_ANG  = -23'sd3294199;
    localparam logic [STEP_W-1:0]         RST_ANGLE_STEP = 23'd18300;

    localparam logic [ANGLE_W:0]          Q_LIMIT   = 25'h1000000;
    localparam logic signed [ANGLE_W+1:0] ANG_MAX   = 26'sd8388607;
    localparam logic signed [ANGLE_W+1:0] ANG_MIN   = -26'sd8388608;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               finite;
        logic               scan_end;
    } t_in;

    typedef struct packed {
        logic                      cluster_valid;
        logic signed [ANGLE_W-1:0] mean_angle;
        logic [RANGE_W-1:0]        mean_range_mm;
        logic [WIDTH_W-1:0]        width_angle;
        logic [MINPTS_W-1:0]       point_count;
        logic                      scan_done;
    } t_out;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_MUL_A,
        S_DIV_A,
        S_DIV_R,
        S_MUL_W,
        S_EMIT,
        S_APPLY,
        S_ENDCHK,
        S_MARK
    } t_state;

    typedef enum logic {
        PH_SAMPLE,
        PH_FLUSH
    } t_phase;

endpackage

@@ hw/rtl/lidar_scan_cluster_segmenter.sv @@
// ----------------------------------------------------------------------------
// lidar_scan_cluster_segmenter
// Range-jump clustering of lidar scans, one range sample per transaction.
//
//   Channel   Signals                          Direction  Payload
//   sample    i_valid / o_stall / i_data       in         t_in
//   cluster   o_valid / i_stall / o_data       out        t_out
//   config    i_cfg_we / i_cfg_idx / i_cfg_data in        register write
//
// Each emitted cluster is computed in the shared bit-serial multiplier and
// divider. Reset is synchronous and clears all control and scan state. A
// stalled output holds the sequencer only when a new result must be
// written; one finished result may wait while the next sample is taken.
// ----------------------------------------------------------------------------
module lidar_scan_cluster_segmenter import lsc_pkg::*; #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW  = $clog2(MAX_SAMPLES + 1);
    localparam int CW  = IW;
    localparam int ISW = 2 * IW;
    localparam int RSW = RANGE_W + CW;
    localparam int AW  = ISW + STEP_W;

    t_state r_state;
    t_state n_state;
    t_phase r_phase;
    logic   r_run;
    logic   r_emitted;
    t_in    r_in;
    logic [IW-1:0] r_cur_idx;

    logic [RANGE_W-1:0]       r_min_range;
    logic [RANGE_W-1:0]       r_max_range;
    logic [RANGE_W-1:0]       r_jump;
    logic [GAP_W-1:0]         r_gap;
    logic [MINPTS_W-1:0]      r_min_pts;
    logic signed [STEP_W-1:0] r_start_ang;
    logic [STEP_W-1:0]        r_step;

    logic [IW-1:0]      r_sample_idx;
    logic               r_open;
    logic [IW-1:0]      r_first;
    logic [IW-1:0]      r_last;
    logic [RANGE_W-1:0] r_last_range;
    logic [CW-1:0]      r_count;
    logic [ISW-1:0]     r_isum;
    logic [RSW-1:0]     r_rsum;

    logic [ANGLE_W-1:0] r_ang;
    logic [RANGE_W-1:0] r_mrange;
    logic [WIDTH_W-1:0] r_wid;

    logic r_out_valid;
    t_out r_out;

    logic                      in_acc;
    logic                      out_free;
    logic                      out_load;
    logic                      samp_ok;
    logic [RANGE_W-1:0]        rdiff;
    logic [IW-1:0]             idx_step;
    logic                      joins;
    logic                      emit_ok;
    logic                      compute;
    t_alu_cmd                  alu_cmd;
    logic [AW-1:0]             alu_a;
    logic [STEP_W-1:0]         alu_b;
    logic                      alu_done;
    logic [AW-1:0]             alu_res;
    logic [AW+ANGLE_W:0]       qx;
    logic [ANGLE_W:0]          q_sat;
    logic signed [ANGLE_W+1:0] ang_sum;
    logic [ANGLE_W-1:0]        ang_sat;
    logic [AW+WIDTH_W-1:0]     wx;
    logic [WIDTH_W-1:0]        wid_sat;
    logic [CW+MINPTS_W-1:0]    cx;
    logic [MINPTS_W-1:0]       cnt_sat;
    logic                      last_done;

    lsc_muldiv #(
        .AW (AW)
    ) u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (alu_cmd),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = ((r_state == S_EMIT) || (r_state == S_MARK)) && out_free;

    assign samp_ok = r_in.finite && (r_cur_idx < IW'(MAX_SAMPLES))
                     && (r_in.range_mm > r_min_range) && (r_in.range_mm < r_max_range);
    assign rdiff   = (r_in.range_mm > r_last_range) ? r_in.range_mm - r_last_range
                                                    : r_last_range - r_in.range_mm;
    assign idx_step = r_cur_idx - r_last;
    assign joins    = r_open && ((IW+GAP_W)'(idx_step) <= (IW+GAP_W)'(r_gap))
                      && (rdiff < r_jump);
    assign emit_ok  = r_open && (r_count != '0)
                      && ((CW+MINPTS_W)'(r_count) >= (CW+MINPTS_W)'(r_min_pts));

    assign qx      = (AW+ANGLE_W+1)'(alu_res);
    assign q_sat   = (qx > (AW+ANGLE_W+1)'(Q_LIMIT)) ? Q_LIMIT : qx[ANGLE_W:0];
    assign ang_sum = (ANGLE_W+2)'(r_start_ang) + signed'((ANGLE_W+2)'(q_sat));
    assign ang_sat = (ang_sum > ANG_MAX) ? ANG_MAX[ANGLE_W-1:0] :
                     (ang_sum < ANG_MIN) ? ANG_MIN[ANGLE_W-1:0] : ang_sum[ANGLE_W-1:0];

    assign wx      = (AW+WIDTH_W)'(alu_res);
    assign wid_sat = (|wx[AW+WIDTH_W-1:WIDTH_W]) ? '1 : wx[WIDTH_W-1:0];
    assign cx      = (CW+MINPTS_W)'(r_count);
    assign cnt_sat = (|cx[CW+MINPTS_W-1:MINPTS_W]) ? '1 : cx[MINPTS_W-1:0];

    // A cluster closed by the scan_end sample itself is the last result unless
    // the one-point cluster it leaves behind is emitted by the flush.
    assign last_done = r_in.scan_end
                       && ((r_phase == PH_FLUSH) || (r_min_pts > MINPTS_W'(1)));

    always_comb begin
        compute = (r_state == S_MUL_A) || (r_state == S_DIV_A)
                  || (r_state == S_DIV_R) || (r_state == S_MUL_W);
        alu_cmd.start = compute && !r_run;
        alu_cmd.op    = ALU_MUL;
        alu_a         = AW'(r_isum);
        alu_b         = r_step;
        case (r_state)
            S_DIV_A: begin
                alu_cmd.op = ALU_DIV;
                alu_a      = alu_res;
                alu_b      = STEP_W'(r_count);
            end
            S_DIV_R: begin
                alu_cmd.op = ALU_DIV;
                alu_a      = AW'(r_rsum);
                alu_b      = STEP_W'(r_count);
            end
            S_MUL_W: begin
                alu_a = AW'(r_last - r_first);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!samp_ok) n_state = S_ENDCHK;
                else if (!joins && emit_ok) n_state = S_MUL_A;
                else n_state = S_APPLY;
            end
            S_MUL_A: begin
                if (r_run && alu_done) n_state = S_DIV_A;
            end
            S_DIV_A: begin
                if (r_run && alu_done) n_state = S_DIV_R;
            end
            S_DIV_R: begin
                if (r_run && alu_done) n_state = S_MUL_W;
            end
            S_MUL_W: begin
                if (r_run && alu_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = (r_phase == PH_SAMPLE) ? S_APPLY : S_IDLE;
            end
            S_APPLY: begin
                n_state = S_ENDCHK;
            end
            S_ENDCHK: begin
                if (!r_in.scan_end) n_state = S_IDLE;
                else if (emit_ok) n_state = S_MUL_A;
                else if (!r_emitted) n_state = S_MARK;
                else n_state = S_IDLE;
            end
            S_MARK: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range <= RST_MIN_RANGE;
            r_max_range <= RST_MAX_RANGE;
            r_jump      <= RST_RANGE_JUMP;
            r_gap       <= RST_GAP_LIMIT;
            r_min_pts   <= RST_MIN_POINTS;
            r_start_ang <= RST_START_ANG;
            r_step      <= RST_ANGLE_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_RANGE:  r_min_range <= i_cfg_data[RANGE_W-1:0];
                CFG_MAX_RANGE:  r_max_range <= i_cfg_data[RANGE_W-1:0];
                CFG_RANGE_JUMP: r_jump      <= i_cfg_data[RANGE_W-1:0];
                CFG_GAP_LIMIT:  r_gap       <= i_cfg_data[GAP_W-1:0];
                CFG_MIN_POINTS: r_min_pts   <= i_cfg_data[MINPTS_W-1:0];
                CFG_START_ANG:  r_start_ang <= signed'(i_cfg_data[STEP_W-1:0]);
                CFG_ANGLE_STEP: r_step      <= i_cfg_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_SAMPLE;
            r_run        <= 1'b0;
            r_emitted    <= 1'b0;
            r_sample_idx <= '0;
            r_open       <= 1'b0;
            r_first      <= '0;
            r_last       <= '0;
            r_last_range <= '0;
            r_count      <= '0;
            r_isum       <= '0;
            r_rsum       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (alu_cmd.start) begin
                r_run <= 1'b1;
            end else if (alu_done) begin
                r_run <= 1'b0;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_emitted <= 1'b0;
                        if (i_data.scan_end) begin
                            r_sample_idx <= '0;
                        end else if (r_sample_idx < IW'(MAX_SAMPLES)) begin
                            r_sample_idx <= r_sample_idx + 1'b1;
                        end
                    end
                end
                S_EVAL: begin
                    r_phase <= PH_SAMPLE;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_emitted <= 1'b1;
                        if (r_phase == PH_FLUSH) begin
                            r_open  <= 1'b0;
                            r_count <= '0;
                            r_isum  <= '0;
                            r_rsum  <= '0;
                        end
                    end
                end
                S_APPLY: begin
                    r_last       <= r_cur_idx;
                    r_last_range <= r_in.range_mm;
                    if (joins) begin
                        r_count <= r_count + 1'b1;
                        r_isum  <= r_isum + ISW'(r_cur_idx);
                        r_rsum  <= r_rsum + RSW'(r_in.range_mm);
                    end else begin
                        r_open  <= 1'b1;
                        r_first <= r_cur_idx;
                        r_count <= CW'(1);
                        r_isum  <= ISW'(r_cur_idx);
                        r_rsum  <= RSW'(r_in.range_mm);
                    end
                end
                S_ENDCHK: begin
                    r_phase <= PH_FLUSH;
                    if (r_in.scan_end && !emit_ok) begin
                        r_open  <= 1'b0;
                        r_count <= '0;
                        r_isum  <= '0;
                        r_rsum  <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in      <= i_data;
            r_cur_idx <= r_sample_idx;
        end
        if (alu_done) begin
            case (r_state)
                S_DIV_A: r_ang    <= ang_sat;
                S_DIV_R: r_mrange <= alu_res[RANGE_W-1:0];
                S_MUL_W: r_wid    <= wid_sat;
                default: begin
                end
            endcase
        end
        if ((r_state == S_EMIT) && out_free) begin
            r_out.cluster_valid <= 1'b1;
            r_out.mean_angle    <= signed'(r_ang);
            r_out.mean_range_mm <= r_mrange;
            r_out.width_angle   <= r_wid;
            r_out.point_count   <= cnt_sat;
            r_out.scan_done     <= last_done;
        end else if ((r_state == S_MARK) && out_free) begin
            r_out.cluster_valid <= 1'b0;
            r_out.mean_angle    <= '0;
            r_out.mean_range_mm <= '0;
            r_out.width_angle   <= '0;
            r_out.point_count   <= '0;
            r_out.scan_done     <= 1'b1;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

@@ hw/rtl/lsc_muldiv.sv @@
// ----------------------------------------------------------------------------
// lsc_muldiv
// Iterative unsigned multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module lsc_muldiv import lsc_pkg::*; #(
    parameter int AW = 49
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_cmd          i_cmd,
    input  logic [AW-1:0]     i_a,
    input  logic [STEP_W-1:0] i_b,
    output logic              o_done,
    output logic [AW-1:0]     o_res
);

    localparam int CNT_W = $clog2(AW + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    t_alu_op           r_op;
    logic [AW-1:0]     r_acc;
    logic [AW-1:0]     r_a;
    logic [STEP_W-1:0] r_b;
    logic [STEP_W-1:0] r_rem;

    logic [AW-1:0]     mul_sum;
    logic [STEP_W:0]   div_trial;
    logic [STEP_W+1:0] div_diff;
    logic              div_ge;

    assign mul_sum   = {r_acc[AW-2:0], 1'b0} + (r_b[STEP_W-1] ? r_a : '0);
    assign div_trial = {r_rem, r_acc[AW-1]};
    assign div_diff  = {1'b0, div_trial} - {2'b00, r_b};
    assign div_ge    = ~div_diff[STEP_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_cnt <= (i_cmd.op == ALU_MUL) ? CNT_W'(STEP_W) : CNT_W'(AW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_cmd.op;
            r_acc <= (i_cmd.op == ALU_MUL) ? '0 : i_a;
            r_a   <= i_a;
            r_b   <= i_b;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            if (r_op == ALU_MUL) begin
                r_acc <= mul_sum;
                r_b   <= {r_b[STEP_W-2:0], 1'b0};
            end else begin
                r_acc <= {r_acc[AW-2:0], div_ge};
                r_rem <= div_ge ? div_diff[STEP_W-1:0] : div_trial[STEP_W-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

endmodule

@@ test/lidar_scan_cluster_segmenter_tb.sv @@
// ----------------------------------------------------------------------------
// lidar_scan_cluster_segmenter_tb
// Self-checking bench for the range-jump scan segmenter. A short table of
// hand-built scans comes first, followed by random scans under a series of
// register settings, including the extremes. Each result the block emits is
// compared field by field against a behavioral segmenter kept inside the
// bench, or against the table's expected value where a row gives one.
// ----------------------------------------------------------------------------
module lidar_scan_cluster_segmenter_tb;
    import lsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SAMPLES   = 4096;
    localparam int SETTLE_CYCLES = 400;
    localparam int QUIET_LIMIT   = 4000;
    localparam int N_DIRECTED    = 23;
    localparam int N_FIXED_CFG   = 7;

    typedef struct packed {
        logic [RANGE_W-1:0]        min_range;
        logic [RANGE_W-1:0]        max_range;
        logic [RANGE_W-1:0]        jump;
        logic [GAP_W-1:0]          gap;
        logic [MINPTS_W-1:0]       min_pts;
        logic signed [STEP_W-1:0]  start;
        logic [STEP_W-1:0]         step;
    } t_seg_cfg;

    typedef struct packed {
        t_in  smp;
        logic typed;
        t_out want;
    } t_dir_row;

    localparam t_out END_MARKER = '{1'b0, 24'sd0, 16'd0, 32'd0, 13'd0, 1'b1};
    localparam t_out PAIR_AT_1000 = '{1'b1, -24'sd3285049, 16'd1000, 32'd18300, 13'd2, 1'b1};

    logic                  i_clk;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    t_in                   i_data     = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    t_out                  o_data;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = CFG_MIN_RANGE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    bit   src_idle_on  = 1'b1;
    bit   sink_idle_on = 1'b1;
    int   error_count  = 0;
    int   quiet_cycles = 0;
    t_out pending_clusters[$];
    t_out step_clusters[$];
    t_out expected_cluster;

    t_seg_cfg cfg = '{RST_MIN_RANGE, RST_MAX_RANGE, RST_RANGE_JUMP, RST_GAP_LIMIT,
                      RST_MIN_POINTS, RST_START_ANG, RST_ANGLE_STEP};
    int unsigned     seg_index    = 0;
    bit              seg_open     = 1'b0;
    int unsigned     seg_first    = 0;
    int unsigned     seg_last     = 0;
    int unsigned     seg_last_rng = 0;
    int unsigned     seg_count    = 0;
    longint unsigned seg_idx_sum  = 0;
    longint unsigned seg_rng_sum  = 0;

    t_dir_row directed_rows [N_DIRECTED] = '{
        '{'{16'd0,     1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd65535, 1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd150,   1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd3000,  1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd1000,  1'b0, 1'b1}, 1'b1, END_MARKER},
        '{'{16'd1000,  1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd1000,  1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd1000,  1'b0, 1'b1}, 1'b1, PAIR_AT_1000},
        '{'{16'd151,   1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd300,   1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd450,   1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd450,   1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd500,   1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd500,   1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd500,   1'b0, 1'b0}, 1'b0, '0},
        '{'{16'd520,   1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd2999,  1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd65535, 1'b0, 1'b1}, 1'b1, END_MARKER},
        '{'{16'd2000,  1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd2100,  1'b1, 1'b1}, 1'b0, '0},
        '{'{16'd2000,  1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd2010,  1'b1, 1'b0}, 1'b0, '0},
        '{'{16'd2500,  1'b1, 1'b1}, 1'b0, '0}
    };

    t_seg_cfg fixed_cfgs [N_FIXED_CFG] = '{
        '{16'd150,   16'd3000,  16'd150,   12'd2,    13'd2,    -23'sd3294199, 23'd18300},
        '{16'd0,     16'd65535, 16'd65535, 12'd4095, 13'd1,    23'sd4194303,  23'd8388607},
        '{16'd65535, 16'd0,     16'd0,     12'd0,    13'd0,    23'h400000,    23'd0},
        '{16'd100,   16'd4000,  16'd0,     12'd3,    13'd1,    23'sd0,        23'd1},
        '{16'd200,   16'd2000,  16'd300,   12'd0,    13'd0,    23'sd3294199,  23'd6588398},
        '{16'd0,     16'd65535, 16'd500,   12'd5,    13'd4096, -23'sd3294199, 23'd18300},
        '{16'd1,     16'd65534, 16'd2000,  12'd1,    13'd8191, 23'sd1000,     23'd4000}
    };

    lidar_scan_cluster_segmenter #(
        .MAX_SAMPLES(MAX_SAMPLES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        if (error_count < 100) begin
            $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        end
        error_count++;
    endtask

    function automatic void close_open_cluster();
        longint unsigned step_w;
        longint unsigned quot;
        longint unsigned wid;
        longint          ang;
        t_out            res;
        step_w = cfg.step;
        if (seg_open && seg_count >= 1 && seg_count >= cfg.min_pts) begin
            quot = (seg_idx_sum * step_w) / seg_count;
            if (quot > 64'h1000000) quot = 64'h1000000;
            ang = cfg.start;
            ang = ang + longint'(quot);
            if (ang > 8388607) ang = 8388607;
            if (ang < -8388608) ang = -8388608;
            wid = longint'(seg_last - seg_first) * step_w;
            res = '0;
            res.cluster_valid = 1'b1;
            res.mean_angle    = ang[ANGLE_W-1:0];
            res.mean_range_mm = RANGE_W'(seg_rng_sum / seg_count);
            res.width_angle   = (wid > 64'hFFFFFFFF) ? 32'hFFFFFFFF : wid[WIDTH_W-1:0];
            res.point_count   = (seg_count > 8191) ? 13'd8191 : seg_count[MINPTS_W-1:0];
            step_clusters.insert(step_clusters.size(), res);
        end
        seg_open    = 1'b0;
        seg_count   = 0;
        seg_idx_sum = 0;
        seg_rng_sum = 0;
    endfunction

    function automatic void segment_sample(input t_in smp);
        int unsigned cur;
        int unsigned rng;
        int unsigned diff;
        bit          joins;
        t_out        last_res;
        step_clusters.delete();
        cur = seg_index;
        rng = smp.range_mm;
        if (smp.finite && cur < MAX_SAMPLES && rng > cfg.min_range && rng < cfg.max_range) begin
            diff  = (rng > seg_last_rng) ? rng - seg_last_rng : seg_last_rng - rng;
            joins = seg_open && (cur - seg_last) <= cfg.gap && diff < cfg.jump;
            if (!joins) begin
                close_open_cluster();
                seg_open  = 1'b1;
                seg_first = cur;
            end
            seg_last     = cur;
            seg_last_rng = rng;
            seg_count++;
            seg_idx_sum += cur;
            seg_rng_sum += rng;
        end
        if (cur < MAX_SAMPLES) seg_index = cur + 1;
        if (smp.scan_end) begin
            close_open_cluster();
            if (step_clusters.size() == 0) step_clusters.insert(0, t_out'('0));
            last_res = step_clusters.pop_back();
            last_res.scan_done = 1'b1;
            step_clusters.insert(step_clusters.size(), last_res);
            seg_index = 0;
        end
    endfunction

    task automatic send_item(input t_in smp, input bit typed, input t_out want);
        while (src_idle_on && $urandom_range(0, 99) < 37) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= smp;
        do @(posedge i_clk); while (o_stall);
        segment_sample(smp);
        if (typed) begin
            pending_clusters.insert(pending_clusters.size(), want);
        end else begin
            foreach (step_clusters[k])
                pending_clusters.insert(pending_clusters.size(), step_clusters[k]);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input t_seg_cfg c);
        write_reg(CFG_MIN_RANGE,  CFG_DATA_W'(c.min_range));
        write_reg(CFG_MAX_RANGE,  CFG_DATA_W'(c.max_range));
        write_reg(CFG_RANGE_JUMP, CFG_DATA_W'(c.jump));
        write_reg(CFG_GAP_LIMIT,  CFG_DATA_W'(c.gap));
        write_reg(CFG_MIN_POINTS, CFG_DATA_W'(c.min_pts));
        write_reg(CFG_START_ANG,  CFG_DATA_W'(c.start));
        write_reg(CFG_ANGLE_STEP, CFG_DATA_W'(c.step));
        i_cfg_we <= 1'b0;
        cfg = c;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_clusters.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic stream_scans(input int n_items);
        int  sent;
        int  len;
        int  lo;
        int  hi;
        int  r;
        int  k;
        int  bound;
        t_in smp;
        sent = 0;
        while (sent < n_items) begin
            len = $urandom_range(1, 24);
            lo  = int'(cfg.min_range) + 1;
            hi  = int'(cfg.max_range) - 1;
            if (lo > hi) begin
                lo = 0;
                hi = 65535;
            end
            r     = $urandom_range(lo, hi);
            bound = (cfg.jump == 0) ? 0 : int'(cfg.jump) - 1;
            for (int j = 0; j < len; j++) begin
                k = $urandom_range(0, 99);
                smp.finite = 1'b1;
                if (k < 10) begin
                    r = $urandom_range(0, 65535);
                    smp.finite = 1'($urandom_range(0, 1));
                end else if (k < 18) begin
                    smp.finite = 1'b0;
                end else if (k < 26) begin
                    r = $urandom_range(lo, hi);
                end else if (k < 31) begin
                    r = r + int'(cfg.jump);
                end else if ($urandom_range(0, 1) == 1) begin
                    r = r + int'($urandom_range(0, bound));
                end else begin
                    r = r - int'($urandom_range(0, bound));
                end
                if (r < 0) r = 0;
                if (r > 65535) r = 65535;
                smp.range_mm = r[RANGE_W-1:0];
                smp.scan_end = (j == len - 1);
                send_item(smp, 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_clusters.size() == 0) begin
                flag_error("transaction with nothing pending", 32'(o_data.point_count), 32'd0);
            end else begin
                expected_cluster = pending_clusters.pop_front();
                if (o_data.cluster_valid !== expected_cluster.cluster_valid)
                    flag_error("cluster_valid", 32'(o_data.cluster_valid),
                               32'(expected_cluster.cluster_valid));
                if (o_data.mean_angle !== expected_cluster.mean_angle)
                    flag_error("mean_angle", 32'(o_data.mean_angle),
                               32'(expected_cluster.mean_angle));
                if (o_data.mean_range_mm !== expected_cluster.mean_range_mm)
                    flag_error("mean_range_mm", 32'(o_data.mean_range_mm),
                               32'(expected_cluster.mean_range_mm));
                if (o_data.width_angle !== expected_cluster.width_angle)
                    flag_error("width_angle", o_data.width_angle,
                               expected_cluster.width_angle);
                if (o_data.point_count !== expected_cluster.point_count)
                    flag_error("point_count", 32'(o_data.point_count),
                               32'(expected_cluster.point_count));
                if (o_data.scan_done !== expected_cluster.scan_done)
                    flag_error("scan_done", 32'(o_data.scan_done),
                               32'(expected_cluster.scan_done));
            end
        end
        i_stall <= sink_idle_on && ($urandom_range(0, 99) < 37);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : sequencer
        t_seg_cfg c;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].smp, directed_rows[k].typed, directed_rows[k].want);
        end
        settle();

        for (int p = 0; p < N_FIXED_CFG; p++) begin
            src_idle_on  = (p != 0);
            sink_idle_on = (p != 0);
            apply_config(fixed_cfgs[p]);
            stream_scans(40);
            settle();
        end

        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int p = 0; p < 3; p++) begin
            c.min_range = RANGE_W'($urandom_range(0, 2000));
            c.max_range = RANGE_W'(int'(c.min_range) + int'($urandom_range(2, 20000)));
            c.jump      = RANGE_W'($urandom_range(0, 1500));
            c.gap       = GAP_W'($urandom_range(0, 6));
            c.min_pts   = MINPTS_W'($urandom_range(0, 5));
            c.start     = STEP_W'($urandom);
            c.step      = STEP_W'($urandom);
            apply_config(c);
            stream_scans(40);
            settle();
        end

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
